/* rtl/distance_smoothing_sleep_controller_macros.svh */
// ----------------------------------------------------------------------------
// Distance smoothing sleep controller assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_SMOOTHING_SLEEP_CONTROLLER_MACROS_SVH
`define DISTANCE_SMOOTHING_SLEEP_CONTROLLER_MACROS_SVH

// same-cycle implication
`define DSSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DSSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dssc_pkg.sv */
// ----------------------------------------------------------------------------
// dssc_pkg
// Types, widths and codes shared by the distance smoothing sleep controller.
// ----------------------------------------------------------------------------
package dssc_pkg;

    localparam int DIST_BITS  = 13;
    localparam int COUNT_BITS = 16;
    localparam int FAIL_BITS  = 6;
    localparam int REG_BITS   = 16;
    localparam int IDX_BITS   = 3;
    localparam int CMP_BITS   = ((COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS) + 2;

    localparam logic [FAIL_BITS-1:0]  FAIL_MAX  = {FAIL_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [IDX_BITS-1:0] REG_STABLE_BAND   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_SLEEP_AFTER   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_FADE_WINDOW   = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_MAX_AWAKE     = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_FAILURE_LIMIT = 3'd4;

    typedef enum logic [1:0] {
        ACT_RENDER = 2'd0,
        ACT_FADE   = 2'd1,
        ACT_HOLD   = 2'd2,
        ACT_ASLEEP = 2'd3
    } action_t;

    typedef struct packed {
        logic [7:0]           stable_band_mm;
        logic [REG_BITS-1:0]  sleep_after_frames;
        logic [REG_BITS-1:0]  fade_window_frames;
        logic [REG_BITS-1:0]  max_awake_frames;
        logic [FAIL_BITS-1:0] failure_limit;
    } cfg_t;

    typedef struct packed {
        logic [DIST_BITS-1:0]  last_distance;
        logic [DIST_BITS-1:0]  shown_distance;
        logic [DIST_BITS-1:0]  reference_distance;
        logic [COUNT_BITS-1:0] stable_frames;
        logic [1:0]            stable_mod3;
        logic [COUNT_BITS-1:0] awake_frames;
        logic [FAIL_BITS-1:0]  failed_reads;
        logic                  sleeping;
    } state_t;

    typedef struct packed {
        logic                 feed_watchdog;
        logic                 restart_request;
        logic                 asleep;
        logic                 wake_up;
        logic                 go_to_sleep;
        action_t              frame_action;
        logic [DIST_BITS-1:0] shown_mm;
    } result_t;

endpackage

/* rtl/distance_smoothing_sleep_controller.sv */
// ----------------------------------------------------------------------------
// distance_smoothing_sleep_controller
// Smooths sensor distance per frame and decides fade, sleep and wake actions.
// ----------------------------------------------------------------------------
//  channel   direction  signals                           content
//  s_*       in         s_tvalid s_tready s_tdata[15:0]   one frame: read outcome, sample
//  m_*       out        m_tvalid m_tready m_tdata[23:0]   one frame result
//  cfg_*     in         cfg_we cfg_index cfg_wdata        register writes, no read-back
//
//  One frame per cycle while m_tready allows; the result is registered at acceptance and shown in the next cycle.
//  State updates at acceptance; a single output register holds the result.
//  s_tready stays high while the output register is empty or being taken.
//  A stalled m_tready holds the result and blocks only the next frame.
//  Reset restores register defaults and clears all frame state.
// ----------------------------------------------------------------------------
`include "distance_smoothing_sleep_controller_macros.svh"

module distance_smoothing_sleep_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // read_ok, sample_mm[12:0], pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,   // shown_mm[12:0], frame_action[1:0],
                                                          // go_to_sleep, wake_up, asleep,
                                                          // restart_request, feed_watchdog, pad
    input  logic                               cfg_we,
    input  logic [dssc_pkg::IDX_BITS-1:0]      cfg_index,
    input  logic [dssc_pkg::REG_BITS-1:0]      cfg_wdata
);

    localparam int RES_BITS = $bits(dssc_pkg::result_t);

    dssc_pkg::cfg_t    cfg_reg;
    dssc_pkg::state_t  state_reg;
    dssc_pkg::state_t  state_next;
    dssc_pkg::result_t result_reg;
    dssc_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              s_accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24 - RES_BITS){1'b0}}, result_reg};

    dssc_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .read_ok    (s_tdata[0]),
        .sample_mm  (s_tdata[dssc_pkg::DIST_BITS:1]),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stable_band_mm     <= 8'd7;
            cfg_reg.sleep_after_frames <= 16'd300;
            cfg_reg.fade_window_frames <= 16'd60;
            cfg_reg.max_awake_frames   <= 16'd1800;
            cfg_reg.failure_limit      <= 6'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dssc_pkg::REG_STABLE_BAND:   cfg_reg.stable_band_mm     <= cfg_wdata[7:0];
                dssc_pkg::REG_SLEEP_AFTER:   cfg_reg.sleep_after_frames <= cfg_wdata;
                dssc_pkg::REG_FADE_WINDOW:   cfg_reg.fade_window_frames <= cfg_wdata;
                dssc_pkg::REG_MAX_AWAKE:     cfg_reg.max_awake_frames   <= cfg_wdata;
                dssc_pkg::REG_FAILURE_LIMIT:
                    cfg_reg.failure_limit <= cfg_wdata[dssc_pkg::FAIL_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            result_reg <= result_next;
        end
    end

    `DSSC_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, s_tready,
        "input stalled with empty output register")
    `DSSC_ASSERT_NOW(a_restart_clean, out_valid_reg && result_reg.restart_request,
        (result_reg.shown_mm == '0) && !result_reg.asleep && !result_reg.feed_watchdog,
        "restart transaction carries nonzero fields")
    `DSSC_ASSERT_NOW(a_sleep_pulse_asleep, out_valid_reg && result_reg.go_to_sleep,
        result_reg.asleep,
        "sleep pulse without asleep flag")
    `DSSC_ASSERT_NOW(a_asleep_action, out_valid_reg && result_reg.asleep,
        result_reg.frame_action == dssc_pkg::ACT_ASLEEP,
        "sleeping frame without asleep action")
    `DSSC_ASSERT_NEXT(a_restart_clears, s_accept && result_next.restart_request,
        (state_reg.failed_reads == '0) && !state_reg.sleeping,
        "state not cleared after restart")

endmodule

/* rtl/dssc_step.sv */
// ----------------------------------------------------------------------------
// dssc_step
// Per-frame update: failure count and restart, smoothing, stability and sleep decision.
// ----------------------------------------------------------------------------
module dssc_step (
    input  dssc_pkg::cfg_t                   cfg,
    input  dssc_pkg::state_t                 state,
    input  logic                             read_ok,
    input  logic [dssc_pkg::DIST_BITS-1:0]   sample_mm,
    output dssc_pkg::state_t                 state_next,
    output dssc_pkg::result_t                result
);

    localparam int DB = dssc_pkg::DIST_BITS;
    localparam int CB = dssc_pkg::COUNT_BITS;
    localparam int MB = dssc_pkg::CMP_BITS;

    logic [dssc_pkg::FAIL_BITS-1:0] failed_next;
    logic                           restart;
    logic [DB-1:0]                  last_d;
    logic signed [DB:0]             gap;
    logic signed [DB:0]             gap_q;
    logic signed [DB:0]             diff;
    logic [DB:0]                    diff_abs;
    logic                           in_band;
    logic [CB-1:0]                  stable_new;
    logic [1:0]                     mod3_new;
    logic                           sleeping1;
    logic                           woke;
    logic [CB-1:0]                  awake1;
    logic [CB-1:0]                  awake2;
    logic signed [MB-1:0]           window_start;
    logic                           sleep_hit;
    logic                           sleep_pulse;
    logic                           sleeping2;
    dssc_pkg::action_t              action;

    always_comb
    begin
        if (read_ok)
        begin
            failed_next = '0;
        end
        else if (state.failed_reads == dssc_pkg::FAIL_MAX)
        begin
            failed_next = state.failed_reads;
        end
        else
        begin
            failed_next = state.failed_reads + 1'b1;
        end
        restart = !read_ok && (failed_next > cfg.failure_limit);
        last_d  = read_ok ? sample_mm : state.last_distance;

        // quarter step, truncated toward zero
        gap   = $signed({1'b0, last_d}) - $signed({1'b0, state.shown_distance});
        gap_q = gap >>> 2;
        if (gap[DB] && (gap[1:0] != 2'b00))
        begin
            gap_q = gap_q + $signed({{DB{1'b0}}, 1'b1});
        end

        diff     = $signed({1'b0, last_d}) - $signed({1'b0, state.reference_distance});
        diff_abs = diff[DB] ? (-diff) : diff;
        in_band  = (MB)'(diff_abs) < (MB)'(cfg.stable_band_mm);

        if (!in_band)
        begin
            stable_new = '0;
            mod3_new   = 2'd0;
        end
        else if (state.stable_frames == dssc_pkg::COUNT_MAX)
        begin
            stable_new = state.stable_frames;
            mod3_new   = state.stable_mod3;
        end
        else
        begin
            stable_new = state.stable_frames + 1'b1;
            mod3_new   = (state.stable_mod3 == 2'd2) ? 2'd0 : state.stable_mod3 + 2'd1;
        end

        woke      = !in_band && state.sleeping;
        sleeping1 = state.sleeping && in_band;
        awake1    = woke ? '0 : state.awake_frames;
        if (!sleeping1 && (awake1 != dssc_pkg::COUNT_MAX))
        begin
            awake2 = awake1 + 1'b1;
        end
        else
        begin
            awake2 = awake1;
        end

        window_start = $signed((MB)'(cfg.sleep_after_frames))
                     - $signed((MB)'(cfg.fade_window_frames));
        sleep_hit = ((MB)'(stable_new) > (MB)'(cfg.sleep_after_frames))
                 || ((MB)'(awake2) > (MB)'(cfg.max_awake_frames));
        sleep_pulse = sleep_hit && !sleeping1;
        sleeping2   = sleeping1 || sleep_hit;

        if (sleep_hit || sleeping2)
        begin
            action = dssc_pkg::ACT_ASLEEP;
        end
        else if ($signed((MB)'(stable_new)) > window_start)
        begin
            action = (mod3_new == 2'd0) ? dssc_pkg::ACT_FADE : dssc_pkg::ACT_HOLD;
        end
        else
        begin
            action = dssc_pkg::ACT_RENDER;
        end

        if (restart)
        begin
            state_next                 = '0;
            result                     = '0;
            result.frame_action        = dssc_pkg::ACT_RENDER;
            result.restart_request     = 1'b1;
        end
        else
        begin
            state_next.last_distance      = last_d;
            state_next.shown_distance     = state.shown_distance + gap_q[DB-1:0];
            state_next.reference_distance = in_band ? state.reference_distance : last_d;
            state_next.stable_frames      = stable_new;
            state_next.stable_mod3        = mod3_new;
            state_next.awake_frames       = awake2;
            state_next.failed_reads       = failed_next;
            state_next.sleeping           = sleeping2;

            result.shown_mm        = state_next.shown_distance;
            result.frame_action    = action;
            result.go_to_sleep     = sleep_pulse;
            result.wake_up         = woke;
            result.asleep          = sleeping2;
            result.restart_request = 1'b0;
            result.feed_watchdog   = read_ok;
        end
    end

endmodule
